// ===== rtl/efla_pkg.sv =====
package efla_pkg;

	localparam int HEAP_BYTES  = 65536;
	localparam int CHUNK_BYTES = 4096;
	localparam int HEAP_IDX_W  = $clog2(HEAP_BYTES / 4);
	localparam int LIM_W       = 17;
	localparam int CHUNK_GROW  = ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;
	localparam int WALK_LIMIT  = HEAP_BYTES / 16 + 2;
	localparam int WALK_W      = $clog2(WALK_LIMIT + 1);
	localparam int INIT_BRK    = 24;

	localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
	localparam logic [31:0] OFS_M8    = 32'hFFFF_FFF8;
	localparam logic [31:0] OFS_M4    = 32'hFFFF_FFFC;
	localparam logic [31:0] OFS_P4    = 32'd4;
	localparam logic [31:0] SENTINEL  = 32'd8;
	localparam logic [31:0] HEAD_ADDR = 32'd12;
	localparam logic [31:0] MIN_BLOCK = 32'd16;
	localparam logic [31:0] ALLOC_BIT = 32'd1;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_NOMEM    = 2'd2;
	localparam logic [1:0] ST_NOT_INIT = 2'd3;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] k;
		logic        sub;
	} alu_op_t;

	typedef struct packed {
		logic                  re;
		logic                  we;
		logic [HEAP_IDX_W-1:0] idx;
		logic [31:0]           wdata;
	} mem_req_t;

	typedef struct packed {
		logic        vld;
		logic [15:0] addr;
		logic [1:0]  status;
	} res_t;

endpackage

// ===== rtl/efla_if.sv =====
interface efla_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] req_size;
	logic [15:0] block_addr;
	modport source(output valid, cmd, req_size, block_addr, input ready);
	modport sink(input valid, cmd, req_size, block_addr, output ready);
endinterface

interface efla_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_addr;
	logic [1:0]  status;
	modport source(output valid, result_addr, status, input ready);
	modport sink(input valid, result_addr, status, output ready);
endinterface

interface efla_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== rtl/efla_ram.sv =====
module efla_ram #(
	parameter int IDX_W  = 14,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              re,
	input  logic              we,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**IDX_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[idx] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[idx];
		end
	end

endmodule

// ===== rtl/efla_alu.sv =====
module efla_alu (
	input  efla_pkg::alu_op_t op,
	output logic [31:0]       y
);

	logic [31:0] b_eff;

	always_comb begin
		b_eff = op.sub ? (32'd0 - op.b) : op.b;
		y     = op.a + b_eff + op.k;
	end

endmodule

// ===== rtl/efla_seq.sv =====
module efla_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  cmd,
	input  logic [15:0]                 req_size,
	input  logic [15:0]                 block_addr,
	input  logic [efla_pkg::LIM_W-1:0]  eff_lim,
	input  logic                        out_free,
	output logic                        idle,
	output efla_pkg::res_t              res,
	output efla_pkg::alu_op_t           op,
	input  logic [31:0]                 alu_y,
	output efla_pkg::mem_req_t          mem,
	input  logic [31:0]                 mem_rdata
);

	localparam logic [6:0] S_IDLE  = 7'd0,   S_CMD   = 7'd1,   S_DONE  = 7'd2;
	localparam logic [6:0] S_U0    = 7'd3,   S_U1    = 7'd4,   S_U2    = 7'd5;
	localparam logic [6:0] S_U3    = 7'd6,   S_U4    = 7'd7,   S_U5    = 7'd8;
	localparam logic [6:0] S_L0    = 7'd9,   S_L1    = 7'd10,  S_L2    = 7'd11;
	localparam logic [6:0] S_L3    = 7'd12,  S_L4    = 7'd13,  S_L5    = 7'd14;
	localparam logic [6:0] S_M0    = 7'd15,  S_M1    = 7'd16,  S_M2    = 7'd17;
	localparam logic [6:0] S_M3    = 7'd18,  S_M4    = 7'd19,  S_M5    = 7'd20;
	localparam logic [6:0] S_M6    = 7'd21,  S_M7    = 7'd22,  S_MLINK = 7'd23;
	localparam logic [6:0] S_MA0   = 7'd24,  S_MA1   = 7'd25,  S_MA2   = 7'd26;
	localparam logic [6:0] S_MA3   = 7'd27,  S_MA4   = 7'd28,  S_MA5   = 7'd29;
	localparam logic [6:0] S_MA6   = 7'd30,  S_MA7   = 7'd31;
	localparam logic [6:0] S_MB0   = 7'd32,  S_MB1   = 7'd33,  S_MB2   = 7'd34;
	localparam logic [6:0] S_MB3   = 7'd35,  S_MB4   = 7'd36,  S_MB5   = 7'd37;
	localparam logic [6:0] S_MB6   = 7'd38,  S_MB7   = 7'd39,  S_MB8   = 7'd40;
	localparam logic [6:0] S_MB9   = 7'd41,  S_MB10  = 7'd42,  S_MB11  = 7'd43;
	localparam logic [6:0] S_MB12  = 7'd44;
	localparam logic [6:0] S_MC0   = 7'd45,  S_MC1   = 7'd46,  S_MC2   = 7'd47;
	localparam logic [6:0] S_MC3   = 7'd48,  S_MC4   = 7'd49,  S_MC5   = 7'd50;
	localparam logic [6:0] S_MC6   = 7'd51,  S_MC7   = 7'd52,  S_MC8   = 7'd53;
	localparam logic [6:0] S_MC9   = 7'd54,  S_MC10  = 7'd55,  S_MC11  = 7'd56;
	localparam logic [6:0] S_MC12  = 7'd57,  S_MC13  = 7'd58,  S_MC14  = 7'd59;
	localparam logic [6:0] S_MC15  = 7'd60,  S_MC16  = 7'd61,  S_MC17  = 7'd62;
	localparam logic [6:0] S_MC18  = 7'd63,  S_MC19  = 7'd64,  S_MC20  = 7'd65;
	localparam logic [6:0] S_MC21  = 7'd66;
	localparam logic [6:0] S_E0    = 7'd67,  S_E1    = 7'd68,  S_E2    = 7'd69;
	localparam logic [6:0] S_E3    = 7'd70,  S_E4    = 7'd71,  S_E5    = 7'd72;
	localparam logic [6:0] S_P0    = 7'd73,  S_P1    = 7'd74,  S_P2    = 7'd75;
	localparam logic [6:0] S_P3    = 7'd76,  S_P4    = 7'd77,  S_P5    = 7'd78;
	localparam logic [6:0] S_P6    = 7'd79,  S_P7    = 7'd80,  S_P8    = 7'd81;
	localparam logic [6:0] S_P9    = 7'd82,  S_P10   = 7'd83;
	localparam logic [6:0] S_PN0   = 7'd84,  S_PN1   = 7'd85,  S_PN2   = 7'd86;
	localparam logic [6:0] S_F0    = 7'd87,  S_F1    = 7'd88,  S_F2    = 7'd89;
	localparam logic [6:0] S_F3    = 7'd90,  S_F4    = 7'd91,  S_NF    = 7'd92;
	localparam logic [6:0] S_X0    = 7'd93;
	localparam logic [6:0] S_I0    = 7'd94,  S_I1    = 7'd95,  S_I2    = 7'd96;
	localparam logic [6:0] S_I3    = 7'd97,  S_I4    = 7'd98,  S_I5    = 7'd99;
	localparam logic [6:0] S_I6    = 7'd100;
	localparam logic [6:0] S_R0    = 7'd101, S_R1    = 7'd102, S_R2    = 7'd103;
	localparam logic [6:0] S_R3    = 7'd104;

	logic [6:0]  state_q, state_d, ret_u_q, ret_m_q;
	logic [1:0]  cmd_q, st_q;
	logic [15:0] req_q, res_q;
	logic [31:0] addr_q, asz_q, g_q, bp_q, pv_q, nx_q, p_q, a_q, b_q;
	logic [31:0] sz_q, whole_q, rem_q, fp_q;
	logic [efla_pkg::WALK_W-1:0] n_q;
	logic        pa_q, na_q, rdy_q;
	logic [efla_pkg::LIM_W-1:0] brk_q;

	logic [31:0] rdm, lim32, g_nf, asz_d;
	logic        grow_fail, init_fail, split_ok;

	always_comb begin
		rdm       = mem_rdata & efla_pkg::SIZE_MASK;
		lim32     = {{(32 - efla_pkg::LIM_W){1'b0}}, eff_lim};
		g_nf      = (asz_q > 32'(efla_pkg::CHUNK_BYTES)) ? asz_q : 32'(efla_pkg::CHUNK_GROW);
		grow_fail = ({{(32 - efla_pkg::LIM_W){1'b0}}, brk_q} + g_nf) > lim32;
		init_fail = 32'(efla_pkg::INIT_BRK + efla_pkg::CHUNK_GROW) > lim32;
		split_ok  = (whole_q >= asz_q) && ((whole_q - asz_q) >= efla_pkg::MIN_BLOCK);
		asz_d     = (req_q <= 16'd8) ? efla_pkg::MIN_BLOCK
		          : (({16'd0, req_q} + 32'd15) & efla_pkg::SIZE_MASK);
	end

	// sequencer: drives the shared adder and the heap port
	always_comb begin
		state_d   = state_q;
		op        = '{a: '0, b: '0, k: '0, sub: 1'b0};
		mem.re    = 1'b0;
		mem.we    = 1'b0;
		mem.wdata = '0;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_CMD;
			S_CMD: begin
				unique case (cmd_q)
					efla_pkg::CMD_INIT:  state_d = S_I0;
					efla_pkg::CMD_ALLOC: begin
						if (!rdy_q || req_q == 16'd0) state_d = S_DONE;
						else state_d = S_F0;
					end
					efla_pkg::CMD_FREE:  state_d = rdy_q ? S_R0 : S_DONE;
					efla_pkg::CMD_NOP:   state_d = S_DONE;
					default:             state_d = S_DONE;
				endcase
			end
			S_DONE: if (out_free) state_d = S_IDLE;
			// unlink p
			S_U0: begin op.a = p_q; mem.re = 1'b1; state_d = S_U1; end
			S_U1: begin op.a = p_q; op.k = efla_pkg::OFS_P4; mem.re = 1'b1; state_d = S_U2; end
			S_U2: begin
				op.a = a_q; op.k = efla_pkg::OFS_P4; mem.we = 1'b1; mem.wdata = mem_rdata;
				state_d = S_U3;
			end
			S_U3: begin op.a = p_q; op.k = efla_pkg::OFS_P4; mem.re = 1'b1; state_d = S_U4; end
			S_U4: begin op.a = p_q; mem.re = 1'b1; state_d = S_U5; end
			S_U5: begin op.a = b_q; mem.we = 1'b1; mem.wdata = mem_rdata; state_d = ret_u_q; end
			// push p at list head
			S_L0: begin op.k = efla_pkg::HEAD_ADDR; mem.re = 1'b1; state_d = S_L1; end
			S_L1: begin
				op.a = p_q; op.k = efla_pkg::OFS_P4; mem.we = 1'b1; mem.wdata = mem_rdata;
				state_d = S_L2;
			end
			S_L2: begin op.a = p_q; mem.we = 1'b1; mem.wdata = efla_pkg::SENTINEL; state_d = S_L3; end
			S_L3: begin op.k = efla_pkg::HEAD_ADDR; mem.re = 1'b1; state_d = S_L4; end
			S_L4: begin op.a = mem_rdata; mem.we = 1'b1; mem.wdata = p_q; state_d = S_L5; end
			S_L5: begin
				op.k = efla_pkg::HEAD_ADDR; mem.we = 1'b1; mem.wdata = p_q; state_d = ret_u_q;
			end
			// coalesce bp
			S_M0: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_M1; end
			S_M1: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_M2; end
			S_M2: begin op.a = pv_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_M3; end
			S_M3: begin
				op.a = pv_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_M4;
			end
			S_M4: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_M5; end
			S_M5: begin
				op.a = bp_q; op.b = rdm; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_M6;
			end
			S_M6: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_M7; end
			S_M7: begin
				if (pa_q && !na_q) state_d = S_MA0;
				else if (!pa_q && na_q) state_d = S_MB0;
				else if (!pa_q && !na_q) state_d = S_MC0;
				else state_d = S_MLINK;
			end
			S_MLINK: state_d = S_L0;
			// next neighbour free
			S_MA0: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MA1; end
			S_MA1: begin op.a = bp_q; op.b = rdm; state_d = S_U0; end
			S_MA2: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MA3; end
			S_MA3: begin
				op.a = bp_q; op.b = rdm; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MA4;
			end
			S_MA4: begin op.a = sz_q; op.b = rdm; state_d = S_MA5; end
			S_MA5: begin
				op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1; mem.wdata = sz_q;
				state_d = S_MA6;
			end
			S_MA6: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MA7; end
			S_MA7: begin
				op.a = bp_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1; mem.wdata = sz_q;
				state_d = S_MLINK;
			end
			// previous neighbour free
			S_MB0: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MB1; end
			S_MB1: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_U0; end
			S_MB2: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MB3; end
			S_MB3: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_MB4; end
			S_MB4: begin op.a = pv_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MB5; end
			S_MB5: begin op.a = sz_q; op.b = rdm; state_d = S_MB6; end
			S_MB6: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MB7; end
			S_MB7: begin
				op.a = bp_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1; mem.wdata = sz_q;
				state_d = S_MB8;
			end
			S_MB8: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MB9; end
			S_MB9: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_MB10; end
			S_MB10: begin
				op.a = pv_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1; mem.wdata = sz_q;
				state_d = S_MB11;
			end
			S_MB11: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MB12; end
			S_MB12: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_MLINK; end
			// both neighbours free
			S_MC0: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MC1; end
			S_MC1: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_U0; end
			S_MC2: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MC3; end
			S_MC3: begin op.a = bp_q; op.b = rdm; state_d = S_U0; end
			S_MC4: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MC5; end
			S_MC5: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_MC6; end
			S_MC6: begin op.a = pv_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MC7; end
			S_MC7: begin op.a = sz_q; op.b = rdm; state_d = S_MC8; end
			S_MC8: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MC9; end
			S_MC9: begin op.a = bp_q; op.b = rdm; state_d = S_MC10; end
			S_MC10: begin op.a = nx_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MC11; end
			S_MC11: begin
				op.a = nx_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MC12;
			end
			S_MC12: begin op.a = sz_q; op.b = rdm; state_d = S_MC13; end
			S_MC13: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MC14; end
			S_MC14: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_MC15; end
			S_MC15: begin
				op.a = pv_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1; mem.wdata = sz_q;
				state_d = S_MC16;
			end
			S_MC16: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MC17; end
			S_MC17: begin op.a = bp_q; op.b = rdm; state_d = S_MC18; end
			S_MC18: begin op.a = nx_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_MC19; end
			S_MC19: begin
				op.a = nx_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1; mem.wdata = sz_q;
				state_d = S_MC20;
			end
			S_MC20: begin op.a = bp_q; op.k = efla_pkg::OFS_M8; mem.re = 1'b1; state_d = S_MC21; end
			S_MC21: begin op.a = bp_q; op.b = rdm; op.sub = 1'b1; state_d = S_MLINK; end
			// grow heap by g at the break
			S_E0: begin op.a = {{(32 - efla_pkg::LIM_W){1'b0}}, brk_q}; op.b = g_q; state_d = S_E1; end
			S_E1: begin
				op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1; mem.wdata = g_q;
				state_d = S_E2;
			end
			S_E2: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_E3; end
			S_E3: begin
				op.a = bp_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1; mem.wdata = g_q;
				state_d = S_E4;
			end
			S_E4: begin op.a = bp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_E5; end
			S_E5: begin
				op.a = bp_q; op.b = rdm; op.k = efla_pkg::OFS_M4; mem.we = 1'b1;
				mem.wdata = efla_pkg::ALLOC_BIT; state_d = S_M0;
			end
			// place request in block fp
			S_P0: begin op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_P1; end
			S_P1: state_d = S_U0;
			S_P2: state_d = split_ok ? S_P3 : S_PN0;
			S_P3: begin
				op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1;
				mem.wdata = asz_q | efla_pkg::ALLOC_BIT; state_d = S_P4;
			end
			S_P4: begin op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_P5; end
			S_P5: begin
				op.a = fp_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1;
				mem.wdata = asz_q | efla_pkg::ALLOC_BIT; state_d = S_P6;
			end
			S_P6: begin op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_P7; end
			S_P7: begin op.a = fp_q; op.b = rdm; state_d = S_P8; end
			S_P8: begin
				op.a = p_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1; mem.wdata = rem_q;
				state_d = S_P9;
			end
			S_P9: begin op.a = p_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_P10; end
			S_P10: begin
				op.a = p_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1; mem.wdata = rem_q;
				state_d = S_L0;
			end
			S_PN0: begin
				op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1;
				mem.wdata = whole_q | efla_pkg::ALLOC_BIT; state_d = S_PN1;
			end
			S_PN1: begin op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_PN2; end
			S_PN2: begin
				op.a = fp_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1;
				mem.wdata = whole_q | efla_pkg::ALLOC_BIT; state_d = S_DONE;
			end
			// first-fit walk
			S_F0: begin op.k = efla_pkg::HEAD_ADDR; mem.re = 1'b1; state_d = S_F1; end
			S_F1: state_d = S_F2;
			S_F2: begin
				if (n_q == efla_pkg::WALK_W'(efla_pkg::WALK_LIMIT)) begin
					state_d = S_NF;
				end else begin
					op.a = fp_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_F3;
				end
			end
			S_F3: begin
				if (mem_rdata[0]) begin
					state_d = S_NF;
				end else if (asz_q <= rdm) begin
					state_d = S_P0;
				end else begin
					op.a = fp_q; op.k = efla_pkg::OFS_P4; mem.re = 1'b1; state_d = S_F4;
				end
			end
			S_F4: state_d = S_F2;
			S_NF: state_d = grow_fail ? S_DONE : S_E0;
			S_X0: state_d = S_P0;
			// initialise
			S_I0: begin
				if (init_fail) begin
					state_d = S_DONE;
				end else begin
					mem.we = 1'b1; state_d = S_I1;
				end
			end
			S_I1: begin
				op.k = 32'd4; mem.we = 1'b1; mem.wdata = efla_pkg::MIN_BLOCK | efla_pkg::ALLOC_BIT;
				state_d = S_I2;
			end
			S_I2: begin
				op.k = efla_pkg::SENTINEL; mem.we = 1'b1; mem.wdata = efla_pkg::SENTINEL;
				state_d = S_I3;
			end
			S_I3: begin
				op.k = efla_pkg::HEAD_ADDR; mem.we = 1'b1; mem.wdata = efla_pkg::SENTINEL;
				state_d = S_I4;
			end
			S_I4: begin
				op.k = efla_pkg::MIN_BLOCK; mem.we = 1'b1;
				mem.wdata = efla_pkg::MIN_BLOCK | efla_pkg::ALLOC_BIT; state_d = S_I5;
			end
			S_I5: begin
				op.k = 32'd20; mem.we = 1'b1; mem.wdata = efla_pkg::ALLOC_BIT; state_d = S_E0;
			end
			S_I6: state_d = S_DONE;
			// free: clear the allocated bit, then coalesce
			S_R0: begin op.a = addr_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_R1; end
			S_R1: begin
				op.a = addr_q; op.k = efla_pkg::OFS_M4; mem.we = 1'b1; mem.wdata = rdm;
				state_d = S_R2;
			end
			S_R2: begin op.a = addr_q; op.k = efla_pkg::OFS_M4; mem.re = 1'b1; state_d = S_R3; end
			S_R3: begin
				op.a = addr_q; op.b = rdm; op.k = efla_pkg::OFS_M8; mem.we = 1'b1;
				mem.wdata = sz_q; state_d = S_M0;
			end
			default: state_d = S_IDLE;
		endcase
		mem.idx = alu_y[efla_pkg::HEAP_IDX_W+1:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_u_q <= S_IDLE;
			ret_m_q <= S_IDLE;
			brk_q   <= '0;
			rdy_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_I0: if (init_fail) begin
					brk_q <= '0;
					rdy_q <= 1'b0;
				end
				S_I5: begin
					brk_q   <= efla_pkg::LIM_W'(efla_pkg::INIT_BRK);
					ret_m_q <= S_I6;
				end
				S_I6:    rdy_q   <= 1'b1;
				S_E0:    brk_q   <= alu_y[efla_pkg::LIM_W-1:0];
				S_NF:    ret_m_q <= S_X0;
				S_R3:    ret_m_q <= S_DONE;
				S_MA1:   ret_u_q <= S_MA2;
				S_MB1:   ret_u_q <= S_MB2;
				S_MC1:   ret_u_q <= S_MC2;
				S_MC3:   ret_u_q <= S_MC4;
				S_MLINK: ret_u_q <= ret_m_q;
				S_P1:    ret_u_q <= S_P2;
				S_P10:   ret_u_q <= S_DONE;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				cmd_q  <= cmd;
				req_q  <= req_size;
				addr_q <= {16'd0, block_addr};
				res_q  <= '0;
				st_q   <= efla_pkg::ST_OK;
			end
			S_CMD: begin
				asz_q <= asz_d;
				if ((cmd_q == efla_pkg::CMD_ALLOC || cmd_q == efla_pkg::CMD_FREE) && !rdy_q) begin
					st_q <= efla_pkg::ST_NOT_INIT;
				end else if (cmd_q == efla_pkg::CMD_ALLOC && req_q == 16'd0) begin
					st_q <= efla_pkg::ST_ZERO;
				end
			end
			S_U1:  a_q  <= mem_rdata;
			S_U4:  b_q  <= mem_rdata;
			S_M1, S_MB3, S_MB9, S_MC5, S_MC14: pv_q <= alu_y;
			S_M4:  pa_q <= mem_rdata[0];
			S_M6:  na_q <= mem_rdata[0];
			S_M7:  sz_q <= rdm;
			S_MLINK: p_q <= bp_q;
			S_MA1, S_MB1, S_MC1, S_MC3, S_P7: p_q <= alu_y;
			S_MA4, S_MB5, S_MC7, S_MC12: sz_q <= alu_y;
			S_MC9, S_MC17: nx_q <= alu_y;
			S_MB12, S_MC21: bp_q <= alu_y;
			S_E0:  bp_q <= {{(32 - efla_pkg::LIM_W){1'b0}}, brk_q};
			S_P1: begin
				whole_q <= rdm;
				p_q     <= fp_q;
			end
			S_P2: begin
				rem_q <= whole_q - asz_q;
				res_q <= fp_q[15:0];
			end
			S_F1: begin
				fp_q <= mem_rdata;
				n_q  <= '0;
			end
			S_F4: begin
				fp_q <= mem_rdata;
				n_q  <= n_q + 1'b1;
			end
			S_NF: begin
				if (grow_fail) st_q <= efla_pkg::ST_NOMEM;
				g_q <= g_nf;
			end
			S_X0:  fp_q <= bp_q;
			S_I0:  if (init_fail) st_q <= efla_pkg::ST_NOMEM;
			S_I5:  g_q  <= 32'(efla_pkg::CHUNK_GROW);
			S_R1:  sz_q <= rdm;
			S_R3:  bp_q <= addr_q;
			default: ;
		endcase
	end

	assign idle       = (state_q == S_IDLE);
	assign res.vld    = (state_q == S_DONE) && out_free;
	assign res.addr   = res_q;
	assign res.status = st_q;

endmodule

// ===== rtl/explicit_free_list_allocator.sv =====
// Boundary-tag heap allocator with an explicit LIFO free list held in a single-port
// 16384 x 32 word store. One command is worked at a time; req.ready is high only
// while the sequencer is idle, and a finished result sits in the output register so
// the next command can be taken while it waits. Every heap access goes through the
// one memory port (read data is registered) and every address through one shared
// adder, so latency is set by the number of word accesses. Initialise writes the
// prologue and epilogue, then grows the heap; free clears the allocated bit and
// merges free neighbours; allocate walks the free list, places and splits, and
// grows the heap first when nothing fits; a zero size, an uninitialised heap or a
// no-op answers without heap access. A result held back by a full output register
// adds the time it waits. The limit register may be written at any time the block
// is idle and is always ready; no clearing pass after reset.
module explicit_free_list_allocator (
	input logic         clk,
	input logic         arst_n,
	efla_req_if.sink    req,
	efla_rsp_if.source  rsp,
	efla_cfg_if.sink    cfg
);

	logic [efla_pkg::LIM_W-1:0] lim_q, eff_lim;
	logic                       out_vld_q, out_free, seq_idle;
	logic [15:0]                out_addr_q;
	logic [1:0]                 out_st_q;
	efla_pkg::res_t             seq_res;
	efla_pkg::alu_op_t          alu_op;
	efla_pkg::mem_req_t         mem_req;
	logic [31:0]                alu_y, mem_rdata;

	assign eff_lim = (lim_q < efla_pkg::LIM_W'(efla_pkg::HEAP_BYTES))
	               ? lim_q : efla_pkg::LIM_W'(efla_pkg::HEAP_BYTES);
	assign out_free  = !out_vld_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign req.ready = seq_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q     <= efla_pkg::LIM_W'(efla_pkg::HEAP_BYTES);
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) lim_q <= cfg.data;
			if (seq_res.vld) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res.vld) begin
			out_addr_q <= seq_res.addr;
			out_st_q   <= seq_res.status;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.result_addr = out_addr_q;
	assign rsp.status      = out_st_q;

	efla_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (req.valid && req.ready),
		.cmd        (req.cmd),
		.req_size   (req.req_size),
		.block_addr (req.block_addr),
		.eff_lim    (eff_lim),
		.out_free   (out_free),
		.idle       (seq_idle),
		.res        (seq_res),
		.op         (alu_op),
		.alu_y      (alu_y),
		.mem        (mem_req),
		.mem_rdata  (mem_rdata)
	);

	efla_alu u_alu (
		.op (alu_op),
		.y  (alu_y)
	);

	efla_ram #(
		.IDX_W  (efla_pkg::HEAP_IDX_W),
		.DATA_W (32)
	) u_ram (
		.clk   (clk),
		.re    (mem_req.re),
		.we    (mem_req.we),
		.idx   (mem_req.idx),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("accepted a second item while busy");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res.vld |=> rsp.valid)
		else $error("finished result not presented");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != efla_pkg::ST_OK) |-> (rsp.result_addr == 16'd0))
		else $error("failed item carries an address");

endmodule

// ===== test/efla_tb_if.sv =====
`timescale 1ns / 100ps
// Interfaces are supplied by the RTL (efla_if.sv); nothing extra is needed here.
package efla_tb_pkg;
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] req_size;
		logic [15:0] block_addr;
	} heap_cmd_t;
	typedef struct packed {
		logic [15:0] addr;
		logic [1:0]  status;
	} heap_rsp_t;
endpackage

// ===== test/explicit_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps
module explicit_free_list_allocator_tb;

	localparam int WORDS = efla_pkg::HEAP_BYTES / 4;
	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	efla_req_if req();
	efla_rsp_if rsp();
	efla_cfg_if cfg();

	explicit_free_list_allocator DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #10 clk = ~clk;

	// shadow heap
	logic [31:0] mem [WORDS];
	logic [16:0] brk;
	logic        live;
	logic [16:0] limit;

	efla_tb_pkg::heap_rsp_t expected_q [$];
	logic [15:0] owned [$];
	int send_idle_pct, stall_pct;
	int fails = 0;
	int cycles = 0;

	function automatic logic [31:0] rd(logic [31:0] a);
		return mem[(a >> 2) % WORDS];
	endfunction
	function automatic void wr(logic [31:0] a, logic [31:0] v);
		mem[(a >> 2) % WORDS] = v;
	endfunction
	function automatic logic [31:0] bsize(logic [31:0] bp);
		return rd(bp - 4) & efla_pkg::SIZE_MASK;
	endfunction
	function automatic logic [31:0] nxt(logic [31:0] bp);
		return bp + bsize(bp);
	endfunction
	function automatic logic [31:0] prv(logic [31:0] bp);
		return bp - (rd(bp - 8) & efla_pkg::SIZE_MASK);
	endfunction
	function automatic logic [31:0] foot(logic [31:0] bp);
		return bp + bsize(bp) - 8;
	endfunction
	function automatic void push_head(logic [31:0] p);
		wr(p + 4, rd(efla_pkg::SENTINEL + 4));
		wr(p, efla_pkg::SENTINEL);
		wr(rd(efla_pkg::SENTINEL + 4), p);
		wr(efla_pkg::SENTINEL + 4, p);
	endfunction
	function automatic void unlink(logic [31:0] p);
		wr(rd(p) + 4, rd(p + 4));
		wr(rd(p + 4), rd(p));
	endfunction
	function automatic logic [31:0] coalesce(logic [31:0] bp);
		logic [31:0] pa, na, sz;
		pa = rd(foot(prv(bp))) & 1;
		na = rd(nxt(bp) - 4) & 1;
		sz = bsize(bp);
		if (pa != 0 && na == 0) begin
			unlink(nxt(bp));
			sz += bsize(nxt(bp));
			wr(bp - 4, sz);
			wr(foot(bp), sz);
		end else if (pa == 0 && na != 0) begin
			unlink(prv(bp));
			sz += bsize(prv(bp));
			wr(foot(bp), sz);
			wr(prv(bp) - 4, sz);
			bp = prv(bp);
		end else if (pa == 0 && na == 0) begin
			unlink(prv(bp));
			unlink(nxt(bp));
			sz += bsize(prv(bp)) + (rd(foot(nxt(bp))) & efla_pkg::SIZE_MASK);
			wr(prv(bp) - 4, sz);
			wr(foot(nxt(bp)), sz);
			bp = prv(bp);
		end
		push_head(bp);
		return bp;
	endfunction
	function automatic logic [31:0] grow_amt(logic [31:0] b);
		logic [31:0] w;
		w = b / 4;
		return (w + (w & 1)) * 4;
	endfunction
	function automatic logic [31:0] cap();
		return (limit < efla_pkg::HEAP_BYTES) ? 32'(limit) : 32'(efla_pkg::HEAP_BYTES);
	endfunction
	function automatic logic [31:0] extend(logic [31:0] sz);
		logic [31:0] bp;
		bp = 32'(brk);
		brk = 17'(brk + sz);
		wr(bp - 4, sz);
		wr(foot(bp), sz);
		wr(nxt(bp) - 4, efla_pkg::ALLOC_BIT);
		return coalesce(bp);
	endfunction
	function automatic void carve(logic [31:0] p, logic [31:0] sz);
		logic [31:0] whole;
		whole = bsize(p);
		unlink(p);
		if (whole >= sz && whole - sz >= efla_pkg::MIN_BLOCK) begin
			wr(p - 4, sz | 1);
			wr(foot(p), sz | 1);
			p = nxt(p);
			wr(p - 4, whole - sz);
			wr(foot(p), whole - sz);
			push_head(p);
		end else begin
			wr(p - 4, whole | 1);
			wr(foot(p), whole | 1);
		end
	endfunction

	function automatic efla_tb_pkg::heap_rsp_t predict_heap(efla_tb_pkg::heap_cmd_t c);
		efla_tb_pkg::heap_rsp_t r;
		logic [31:0] sz, p, bp, g;
		bit found;
		r = '0;
		if (c.cmd == efla_pkg::CMD_INIT) begin
			if (efla_pkg::INIT_BRK + efla_pkg::CHUNK_GROW > cap()) begin
				brk = '0;
				live = 1'b0;
				r.status = efla_pkg::ST_NOMEM;
			end else begin
				wr(0, 0);
				wr(4, efla_pkg::MIN_BLOCK | 1);
				wr(8, efla_pkg::SENTINEL);
				wr(12, efla_pkg::SENTINEL);
				wr(16, efla_pkg::MIN_BLOCK | 1);
				wr(20, efla_pkg::ALLOC_BIT);
				brk = 17'(efla_pkg::INIT_BRK);
				void'(extend(32'(efla_pkg::CHUNK_GROW)));
				live = 1'b1;
			end
		end else if (c.cmd == efla_pkg::CMD_ALLOC) begin
			if (!live) r.status = efla_pkg::ST_NOT_INIT;
			else if (c.req_size == 0) r.status = efla_pkg::ST_ZERO;
			else begin
				sz = (c.req_size <= 8) ? efla_pkg::MIN_BLOCK
				   : 8 * ((32'(c.req_size) + 15) / 8);
				found = 0;
				p = rd(efla_pkg::SENTINEL + 4);
				for (int n = 0; n < efla_pkg::WALK_LIMIT && (rd(p - 4) & 1) == 0; n++) begin
					if (sz <= bsize(p)) begin
						found = 1;
						break;
					end
					p = rd(p + 4);
				end
				if (found) begin
					carve(p, sz);
					r.addr = p[15:0];
				end else begin
					g = grow_amt(sz > efla_pkg::CHUNK_BYTES ? sz : efla_pkg::CHUNK_BYTES);
					if (32'(brk) + g > cap()) r.status = efla_pkg::ST_NOMEM;
					else begin
						bp = extend(g);
						carve(bp, sz);
						r.addr = bp[15:0];
					end
				end
			end
		end else if (c.cmd == efla_pkg::CMD_FREE) begin
			if (!live) r.status = efla_pkg::ST_NOT_INIT;
			else begin
				sz = bsize(32'(c.block_addr));
				wr(32'(c.block_addr) - 4, sz);
				wr(foot(32'(c.block_addr)), sz);
				void'(coalesce(32'(c.block_addr)));
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("explicit_free_list_allocator_tb failed");
			$finish;
		end
	end

	// result checker and receiver stalls
	always @(posedge clk) begin
		efla_tb_pkg::heap_rsp_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result addr %0d status %0d", $time,
						rsp.result_addr, rsp.status);
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.result_addr !== want.addr || rsp.status !== want.status) begin
						$display("%0t expected addr %0d status %0d, got addr %0d status %0d",
							$time, want.addr, want.status, rsp.result_addr, rsp.status);
						fails++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end else begin
			rsp.ready <= 1'b0;
		end
	end

	// valid stays high into the next item unless the sender idles
	task automatic send_cmd(logic [1:0] c, logic [15:0] sz, logic [15:0] a);
		efla_tb_pkg::heap_cmd_t item;
		efla_tb_pkg::heap_rsp_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item = '{cmd: c, req_size: sz, block_addr: a};
		req.valid <= 1'b1;
		req.cmd <= c;
		req.req_size <= sz;
		req.block_addr <= a;
		do @(posedge clk); while (!req.ready);
		r = predict_heap(item);
		expected_q.push_back(r);
		if (c == efla_pkg::CMD_ALLOC && r.status == efla_pkg::ST_OK) owned.push_back(r.addr);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_limit(logic [16:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		limit = v;
	endtask

	task automatic free_some(int k);
		int j;
		for (int i = 0; i < k && owned.size() != 0; i++) begin
			j = $urandom_range(owned.size() - 1);
			send_cmd(efla_pkg::CMD_FREE, '0, owned[j]);
			owned.delete(j);
		end
	endtask

	task automatic test_directed();
		send_cmd(efla_pkg::CMD_ALLOC, 16'd8, '0);
		send_cmd(efla_pkg::CMD_FREE, '0, 16'd0);
		send_cmd(efla_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF);
		send_cmd(efla_pkg::CMD_INIT, '0, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd0, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd1, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd8, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd9, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd100, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd24, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd5000, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'hFFFF, '0);
		// frees to hit the no-merge, next-free and both-free merge cases
		send_cmd(efla_pkg::CMD_FREE, '0, owned[1]);
		send_cmd(efla_pkg::CMD_FREE, '0, owned[3]);
		send_cmd(efla_pkg::CMD_FREE, '0, owned[2]);
		send_cmd(efla_pkg::CMD_FREE, '0, owned[0]);
		send_cmd(efla_pkg::CMD_FREE, '0, owned[5]);
		owned.delete();
		send_cmd(efla_pkg::CMD_ALLOC, 16'd4088, '0);
		send_cmd(efla_pkg::CMD_INIT, '0, '0);
	endtask

	task automatic test_limits();
		write_limit(17'd24);
		send_cmd(efla_pkg::CMD_INIT, '0, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd4, '0);
		write_limit(17'd4120);
		send_cmd(efla_pkg::CMD_INIT, '0, '0);
		owned.delete();
		send_cmd(efla_pkg::CMD_ALLOC, 16'd3000, '0);
		send_cmd(efla_pkg::CMD_ALLOC, 16'd3000, '0);
		free_some(2);
		write_limit(17'h1FFFF);
		send_cmd(efla_pkg::CMD_INIT, '0, '0);
		owned.delete();
	endtask

	task automatic test_random(int n, int idle, int stall);
		int r;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50 || owned.size() == 0) begin
				if ($urandom_range(19) == 0) send_cmd(efla_pkg::CMD_ALLOC, 16'($urandom), '0);
				else if ($urandom_range(29) == 0) send_cmd(efla_pkg::CMD_ALLOC, 16'd0, '0);
				else send_cmd(efla_pkg::CMD_ALLOC, 16'($urandom_range(1, 600)), '0);
			end else if (r < 92) free_some(1);
			else if (r < 96) send_cmd(efla_pkg::CMD_NOP, 16'($urandom), 16'($urandom));
			else begin
				send_cmd(efla_pkg::CMD_INIT, '0, '0);
				owned.delete();
			end
		end
	endtask

	initial begin
		req.valid = 1'b0; req.cmd = efla_pkg::CMD_NOP; req.req_size = '0; req.block_addr = '0;
		cfg.valid = 1'b0; cfg.data = '0;
		for (int i = 0; i < WORDS; i++) mem[i] = '0;
		brk = '0; live = 1'b0; limit = 17'd65536;
		send_idle_pct = 0; stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_random(110, 0, 0);
		test_random(110, 58, 0);
		write_limit(17'd20000);
		test_random(110, 0, 58);
		write_limit(17'd65536);
		test_random(110, 23, 23);
		drain();
		if (fails == 0) $display("explicit_free_list_allocator_tb passed");
		else $display("explicit_free_list_allocator_tb failed");
		$finish;
	end
endmodule

// ===== explicit_free_list_allocator.f =====
rtl/efla_pkg.sv
rtl/efla_if.sv
rtl/efla_ram.sv
rtl/efla_alu.sv
rtl/efla_seq.sv
rtl/explicit_free_list_allocator.sv
test/efla_tb_if.sv
test/explicit_free_list_allocator_tb.sv
